// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions for the json string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // input transfer payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } jsu_in_t;

  // result transfer payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [2:0] status;
  } jsu_out_t;

  // status codes
  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_DONE     = 3'd1,
    ST_BAD_OPEN = 3'd2,
    ST_BAD_ESC  = 3'd3,
    ST_BAD_HEX  = 3'd4,
    ST_BAD_SURR = 3'd5,
    ST_UNTERM   = 3'd6
  } jsu_status_t;

  // decoder modes, one-hot
  typedef enum logic [6:0] {
    MODE_OPEN    = 7'b0000001,
    MODE_BODY    = 7'b0000010,
    MODE_ESC     = 7'b0000100,
    MODE_HEX1    = 7'b0001000,
    MODE_NEED_BS = 7'b0010000,
    MODE_NEED_U  = 7'b0100000,
    MODE_HEX2    = 7'b1000000
  } jsu_mode_t;

  // up to four utf-8 bytes, index of the last one
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } jsu_utf8_t;

  // everything one input byte produces
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            has_bytes;
    jsu_status_t     status;
  } jsu_bundle_t;

  // characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] BS_CODE  = 8'h08;
  localparam logic [7:0] FF_CODE  = 8'h0C;
  localparam logic [7:0] LF_CODE  = 8'h0A;
  localparam logic [7:0] CR_CODE  = 8'h0D;
  localparam logic [7:0] TAB_CODE = 8'h09;

  // surrogate ranges and supplementary plane base
  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // hex digit value, bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end
    return 5'b10000;
  endfunction

  // code point to utf-8, one to four bytes
  function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
    jsu_utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.bytes[0] = {1'b0, cp[6:0]};
      r.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// Input register and the per-byte decode step: escape handling, hex
// accumulation, surrogate pairing and utf-8 encoding into one bundle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module jsu_decode (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  jsu_pkg::jsu_in_t     in_data,
  output logic                 bnd_valid,
  output jsu_pkg::jsu_bundle_t bnd,
  input  wire                  bnd_ready
);
  import jsu_pkg::*;

  logic        inr_valid_r, inr_valid_nxt;
  jsu_in_t     inr_data_r;
  logic        in_xfer;
  logic        dec_go;

  jsu_mode_t   mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hi_r, hi_nxt;

  logic [7:0]  c;
  logic [4:0]  hex_v;
  logic [15:0] acc_full;
  logic [20:0] cp_surr;
  jsu_utf8_t   enc_bmp, enc_surr;

  // input register handshake
  assign dec_go        = inr_valid_r && bnd_ready;
  assign in_stall      = inr_valid_r && !bnd_ready;
  assign in_xfer       = in_valid && !in_stall;
  assign inr_valid_nxt = in_xfer || (inr_valid_r && !dec_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_valid_r <= 1'b0;
    end else begin
      inr_valid_r <= inr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      inr_data_r <= in_data;
    end
  end

  // operands of the step
  assign c        = inr_data_r.in_byte;
  assign hex_v    = hex_value(c);
  assign acc_full = {acc_r[11:0], hex_v[3:0]};
  assign cp_surr  = SUPP_BASE + {1'b0, hi_r, acc_full[9:0]};
  assign enc_bmp  = utf8_encode({5'd0, acc_full});
  assign enc_surr = utf8_encode(cp_surr);

  // one decode step
  always_comb begin
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    hi_nxt        = hi_r;
    bnd           = '0;
    bnd.status    = ST_RUN;
    case (mode_r)
      MODE_BODY: begin
        if (c == CH_QUOTE) begin
          bnd.status = ST_DONE;
        end else if (c == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          bnd.bytes[0]  = c;
          bnd.has_bytes = 1'b1;
        end
      end
      MODE_ESC: begin
        mode_nxt      = MODE_BODY;
        bnd.has_bytes = 1'b1;
        case (c)
          CH_B: bnd.bytes[0] = BS_CODE;
          CH_F: bnd.bytes[0] = FF_CODE;
          CH_N: bnd.bytes[0] = LF_CODE;
          CH_R: bnd.bytes[0] = CR_CODE;
          CH_T: bnd.bytes[0] = TAB_CODE;
          CH_QUOTE, CH_BSLASH, CH_SLASH: bnd.bytes[0] = c;
          CH_U: begin
            bnd.has_bytes = 1'b0;
            mode_nxt      = MODE_HEX1;
            acc_nxt       = '0;
            cnt_nxt       = '0;
          end
          default: begin
            bnd.has_bytes = 1'b0;
            bnd.status    = ST_BAD_ESC;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2: begin
        if (hex_v[4]) begin
          bnd.status = ST_BAD_HEX;
        end else begin
          acc_nxt = acc_full;
          if (cnt_r != 2'd3) begin
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = '0;
            if (mode_r == MODE_HEX1) begin
              if (acc_full inside {[LO_SURR_MIN:LO_SURR_MAX]}) begin
                bnd.status = ST_BAD_SURR;
              end else if (acc_full inside {[HI_SURR_MIN:HI_SURR_MAX]}) begin
                hi_nxt   = acc_full[9:0];
                mode_nxt = MODE_NEED_BS;
              end else begin
                bnd.bytes     = enc_bmp.bytes;
                bnd.last_idx  = enc_bmp.last_idx;
                bnd.has_bytes = 1'b1;
                mode_nxt      = MODE_BODY;
              end
            end else begin
              if (!(acc_full inside {[LO_SURR_MIN:LO_SURR_MAX]})) begin
                bnd.status = ST_BAD_SURR;
              end else begin
                bnd.bytes     = enc_surr.bytes;
                bnd.last_idx  = enc_surr.last_idx;
                bnd.has_bytes = 1'b1;
                mode_nxt      = MODE_BODY;
                hi_nxt        = '0;
              end
            end
          end
        end
      end
      MODE_NEED_BS: begin
        if (c == CH_BSLASH) begin
          mode_nxt = MODE_NEED_U;
        end else begin
          bnd.status = ST_BAD_SURR;
        end
      end
      MODE_NEED_U: begin
        if (c == CH_U) begin
          mode_nxt = MODE_HEX2;
          acc_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          bnd.status = ST_BAD_SURR;
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          mode_nxt = MODE_BODY;
        end else begin
          bnd.status = ST_BAD_OPEN;
        end
      end
    endcase

    // buffer ran out before the string ended: drop the bytes
    if (bnd.status == ST_RUN && inr_data_r.final_byte) begin
      bnd.status    = ST_UNTERM;
      bnd.bytes     = '0;
      bnd.last_idx  = '0;
      bnd.has_bytes = 1'b0;
    end

    // end of string or error: back to waiting for the opening quote
    if (bnd.status != ST_RUN) begin
      mode_nxt = MODE_OPEN;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      hi_nxt   = '0;
    end
  end

  assign bnd_valid = inr_valid_r;

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OPEN;
      acc_r  <= '0;
      cnt_r  <= '0;
      hi_r   <= '0;
    end else if (dec_go) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      hi_r   <= hi_nxt;
    end
  end

  `ASSERT_NEXT(a_clear_after_end, clk, rst_n, dec_go && bnd.status != ST_RUN, mode_r == MODE_OPEN && acc_r == '0 && hi_r == '0, "state not cleared after end of string")
  `ASSERT_IMPLIES(a_status_no_bytes, clk, rst_n, bnd_valid && bnd.status != ST_RUN, !bnd.has_bytes, "bytes decoded alongside a final status")

endmodule

`default_nettype wire

// ===== rtl/jsu_serial.sv =====
// ----------------------------------------------------------------------------
// jsu_serial
// Result register: holds one decoded bundle and hands its bytes out one
// transfer at a time, marking the last of the run.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module jsu_serial (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  bnd_valid,
  input  jsu_pkg::jsu_bundle_t bnd,
  output logic                 bnd_ready,
  output logic                 out_valid,
  input  wire                  out_stall,
  output jsu_pkg::jsu_out_t    out_data
);
  import jsu_pkg::*;

  logic        bv_r, bv_nxt;
  jsu_bundle_t b_r;
  logic [1:0]  idx_r, idx_nxt;
  logic        cur_last;
  logic        out_xfer;
  logic        run_done;
  logic        load;

  // handshake and hand-over
  assign cur_last  = (idx_r == b_r.last_idx);
  assign out_xfer  = bv_r && !out_stall;
  assign run_done  = out_xfer && cur_last;
  assign bnd_ready = !bv_r || run_done;
  assign load      = bnd_valid && bnd_ready;
  assign bv_nxt    = load || (bv_r && !run_done);

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = '0;
    end else if (out_xfer) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      bv_r  <= bv_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_r <= bnd;
    end
  end

  // result fields
  assign out_valid           = bv_r;
  assign out_data.out_byte   = b_r.bytes[idx_r];
  assign out_data.byte_valid = b_r.has_bytes;
  assign out_data.last       = cur_last;
  assign out_data.status     = b_r.status;

  `ASSERT_IMPLIES(a_empty_is_last, clk, rst_n, out_valid && !out_data.byte_valid, out_data.last, "status-only result not marked last")
  `ASSERT_IMPLIES(a_bytes_running, clk, rst_n, out_valid && out_data.byte_valid, out_data.status == ST_RUN, "decoded byte with non-running status")
  `ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && !out_stall && !out_data.last, out_valid && out_data.byte_valid, "run cut short")

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape_utf8.sv =====
// Path: a byte passes the input register, then the result register, before
// its first result appears.
// Throughput: one input byte per cycle while out_stall is low and each byte
// yields one result; multi-byte utf-8 output holds the result register.
// Reset: synchronous, active low; the decoder waits for an opening quote.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes a json string literal byte by byte into utf-8, reporting done
// or an error status at the end of each string.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  jsu_pkg::jsu_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output jsu_pkg::jsu_out_t  out_data
);
  import jsu_pkg::*;

  logic        bnd_valid;
  logic        bnd_ready;
  jsu_bundle_t bnd;

  // decode step behind the input register
  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .bnd_valid (bnd_valid),
    .bnd       (bnd),
    .bnd_ready (bnd_ready)
  );

  // result register and byte serialiser
  jsu_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .bnd_valid (bnd_valid),
    .bnd       (bnd),
    .bnd_ready (bnd_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives json string literals byte by byte into the unescaper, with random
// gaps on the input side and random stalls on the result side. Each
// accepted byte is run through a local decoder model and the utf-8 bytes
// and status it should produce are queued, then compared field by field
// with every result transfer.
// ----------------------------------------------------------------------------

module tb_top;

  import jsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 250;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  jsu_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  jsu_out_t out_data;

  // decoder model state
  jsu_mode_t   dec_mode;
  logic [15:0] hex_acc;
  logic [1:0]  hex_cnt;
  logic [9:0]  hi_bits;

  jsu_out_t    expected_results[$];
  logic [7:0]  str_bytes[$];

  int unsigned sender_gap_max = 10;
  int unsigned sink_gap_max   = 10;
  int unsigned hold_cycles    = 0;
  int unsigned cycle_count    = 0;
  int unsigned fail_count     = 0;
  int unsigned bytes_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned strings_done   = 0;
  int unsigned strings_failed = 0;

  json_string_unescape_utf8 uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  function automatic void clear_decoder();
    dec_mode = MODE_OPEN;
    hex_acc  = '0;
    hex_cnt  = '0;
    hi_bits  = '0;
  endfunction

  // digit value in the low nibble, bit 4 flags a non-hex character
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39)
      return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  // code point to utf-8, returns the byte count
  function automatic int unsigned utf8_of(input logic [20:0] cp,
                                          output logic [3:0][7:0] seq);
    seq = '0;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      seq[0] = 8'hC0 | cp[10:6];
      seq[1] = 8'h80 | cp[5:0];
      return 2;
    end
    if (cp < 21'h10000) begin
      seq[0] = 8'hE0 | cp[15:12];
      seq[1] = 8'h80 | cp[11:6];
      seq[2] = 8'h80 | cp[5:0];
      return 3;
    end
    seq[0] = 8'hF0 | cp[20:18];
    seq[1] = 8'h80 | cp[17:12];
    seq[2] = 8'h80 | cp[11:6];
    seq[3] = 8'h80 | cp[5:0];
    return 4;
  endfunction

  // advance the model by one accepted byte and queue what it yields
  task automatic decode_byte(input jsu_in_t item);
    logic [7:0]       c;
    logic [4:0]       dv;
    logic [3:0][7:0]  seq;
    int unsigned      nb;
    jsu_status_t      st;
    jsu_out_t         r;
    c   = item.in_byte;
    seq = '0;
    nb  = 0;
    st  = ST_RUN;
    case (dec_mode)
      MODE_BODY: begin
        if (c == CH_QUOTE) st = ST_DONE;
        else if (c == CH_BSLASH) dec_mode = MODE_ESC;
        else begin
          seq[0] = c;
          nb = 1;
        end
      end
      MODE_ESC: begin
        dec_mode = MODE_BODY;
        nb = 1;
        case (c)
          CH_B: seq[0] = BS_CODE;
          CH_F: seq[0] = FF_CODE;
          CH_N: seq[0] = LF_CODE;
          CH_R: seq[0] = CR_CODE;
          CH_T: seq[0] = TAB_CODE;
          CH_QUOTE, CH_BSLASH, CH_SLASH: seq[0] = c;
          CH_U: begin
            nb = 0;
            dec_mode = MODE_HEX1;
            hex_acc = '0;
            hex_cnt = '0;
          end
          default: begin
            nb = 0;
            st = ST_BAD_ESC;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2: begin
        dv = digit_of(c);
        if (dv[4]) st = ST_BAD_HEX;
        else begin
          hex_acc = {hex_acc[11:0], dv[3:0]};
          if (hex_cnt != 2'd3) hex_cnt = hex_cnt + 2'd1;
          else begin
            hex_cnt = '0;
            if (dec_mode == MODE_HEX1) begin
              if (hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX) st = ST_BAD_SURR;
              else if (hex_acc >= HI_SURR_MIN && hex_acc <= HI_SURR_MAX) begin
                hi_bits = hex_acc[9:0];
                dec_mode = MODE_NEED_BS;
              end else begin
                nb = utf8_of({5'd0, hex_acc}, seq);
                dec_mode = MODE_BODY;
              end
            end else if (hex_acc < LO_SURR_MIN || hex_acc > LO_SURR_MAX) begin
              st = ST_BAD_SURR;
            end else begin
              nb = utf8_of(SUPP_BASE + {1'b0, hi_bits, hex_acc[9:0]}, seq);
              dec_mode = MODE_BODY;
              hi_bits = '0;
            end
          end
        end
      end
      MODE_NEED_BS: begin
        if (c == CH_BSLASH) dec_mode = MODE_NEED_U;
        else st = ST_BAD_SURR;
      end
      MODE_NEED_U: begin
        if (c == CH_U) begin
          dec_mode = MODE_HEX2;
          hex_acc = '0;
          hex_cnt = '0;
        end else begin
          st = ST_BAD_SURR;
        end
      end
      default: begin
        if (c == CH_QUOTE) dec_mode = MODE_BODY;
        else st = ST_BAD_OPEN;
      end
    endcase

    // a final byte that leaves the string open drops what it decoded
    if (st == ST_RUN && item.final_byte) begin
      st = ST_UNTERM;
      nb = 0;
    end
    if (st == ST_DONE) strings_done++;
    else if (st != ST_RUN) strings_failed++;
    if (st != ST_RUN) clear_decoder();

    if (nb == 0) begin
      r = '0;
      r.last = 1'b1;
      r.status = st;
      expected_results.push_back(r);
    end else begin
      for (int unsigned k = 0; k < nb; k++) begin
        r.out_byte   = seq[k];
        r.byte_valid = 1'b1;
        r.last       = (k == nb - 1);
        r.status     = ST_RUN;
        expected_results.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // random stall before each result, or a long hold when one is requested
  initial begin : result_sink
    int unsigned stall_left;
    bit          taken;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      taken = out_valid && !out_stall;
      @(negedge clk);
      if (hold_cycles > 0) begin
        stall_left = hold_cycles;
        hold_cycles = 0;
      end else if (taken) begin
        stall_left = $urandom_range(0, sink_gap_max);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    jsu_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, out_data.byte_valid});
        check_field("last", {7'd0, want.last}, {7'd0, out_data.last});
        check_field("status", {5'd0, want.status}, {5'd0, out_data.status});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one input transfer, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] c, input logic fin);
    int unsigned gap;
    jsu_in_t     item;
    item.in_byte = c;
    item.final_byte = fin;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    decode_byte(item);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_pending(input bit fin_last);
    int unsigned n;
    n = str_bytes.size();
    for (int unsigned i = 0; i < n; i++)
      send_byte(str_bytes[i], fin_last && (i == n - 1));
    str_bytes.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  task automatic push_hex_escape(input logic [15:0] code);
    str_bytes.push_back(CH_BSLASH);
    str_bytes.push_back(CH_U);
    for (int i = 3; i >= 0; i--)
      str_bytes.push_back(hex_char(code[i*4 +: 4], 1'($urandom_range(0, 1))));
  endtask

  function automatic logic [7:0] escape_letter(input int unsigned idx);
    case (idx)
      0: return CH_B;
      1: return CH_F;
      2: return CH_N;
      3: return CH_R;
      4: return CH_T;
      5: return CH_QUOTE;
      6: return CH_BSLASH;
      default: return CH_SLASH;
    endcase
  endfunction

  // stop offering and wait until every expected result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // plain bytes at the extremes and every single-character escape
  task automatic test_plain_and_escapes();
    push_str("\"A");
    str_bytes.push_back(8'h00);
    str_bytes.push_back(8'hFF);
    push_str("\\b\\f\\n\\r\\t\\\"\\\\\\/\"");
    send_pending(1'b1);
    drain();
  endtask

  // \u codes at every utf-8 length boundary and surrogate pair extremes
  task automatic test_unicode();
    push_str("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF");
    push_str("\\uD800\\uDC00\\udbff\\udfff\"");
    send_pending(1'b0);
    drain();
  endtask

  // every error status except unterminated, each followed by a fresh string
  task automatic test_error_paths();
    push_str("x");
    str_bytes.push_back(8'hFF);
    push_str("\"\\q");
    push_str("\"\\u12\"");
    push_str("\"\\u1g");
    push_str("\"\\uDC00");
    push_str("\"\\uD800a");
    push_str("\"\\uD800\\n");
    push_str("\"\\uD800\\u0041");
    push_str("\"\\uDBFF\\uE000");
    push_str("\"ok\"");
    send_pending(1'b0);
    drain();
  endtask

  // final byte arriving in the open, body, escape, first-hex and need-u states
  task automatic test_unterminated();
    push_str("\"");
    send_pending(1'b1);
    push_str("\"\\");
    send_pending(1'b1);
    push_str("\"ab");
    send_pending(1'b1);
    push_str("\"\\u00e9");
    send_pending(1'b1);
    push_str("\"\\uD83D");
    send_pending(1'b1);
    push_str("\"\\uD83D\\u");
    send_pending(1'b1);
    push_str("\"\\\"");
    send_pending(1'b1);
    drain();
  endtask

  // long result hold while the sender keeps offering bytes
  task automatic test_back_pressure();
    sender_gap_max = 0;
    hold_cycles = 300;
    str_bytes.push_back(CH_QUOTE);
    for (int i = 0; i < 6; i++) push_hex_escape(16'h20AC);
    push_hex_escape(16'hD83D);
    push_hex_escape(16'hDE00);
    str_bytes.push_back(CH_QUOTE);
    send_pending(1'b0);
    drain();
    sender_gap_max = 10;
  endtask

  // mostly well-formed strings with random content, some corrupt or cut
  task automatic test_random_strings();
    int unsigned sent_here;
    int unsigned pick;
    int unsigned segs;
    int unsigned cut;
    logic [7:0]  b;
    logic [15:0] code;
    sent_here = 0;
    while (sent_here < RANDOM_ITEMS) begin
      // idling pattern for this string, including no idling at all
      pick = $urandom_range(0, 3);
      sender_gap_max = pick[0] ? 10 : 0;
      sink_gap_max = pick[1] ? 10 : 0;

      pick = $urandom_range(0, 99);
      if (pick >= 95) begin
        repeat ($urandom_range(1, 6)) str_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        str_bytes.push_back(CH_QUOTE);
        segs = $urandom_range(0, 8);
        repeat (segs) begin
          case ($urandom_range(0, 5))
            0, 1: begin
              do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
              str_bytes.push_back(b);
            end
            2: begin
              str_bytes.push_back(CH_BSLASH);
              str_bytes.push_back(escape_letter($urandom_range(0, 7)));
            end
            3, 4: begin
              case ($urandom_range(0, 2))
                0: code = 16'($urandom_range(0, 16'h7F));
                1: code = 16'($urandom_range(16'h80, 16'h7FF));
                default: begin
                  code = 16'($urandom_range(16'h800, 16'hFFFF));
                  if (code >= HI_SURR_MIN && code <= LO_SURR_MAX) code[13] = 1'b1;
                end
              endcase
              push_hex_escape(code);
            end
            default: begin
              push_hex_escape(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
              push_hex_escape(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
            end
          endcase
        end
        str_bytes.push_back(CH_QUOTE);

        // cut short, or one byte replaced by noise
        if (pick >= 85) begin
          cut = $urandom_range(1, str_bytes.size());
          while (str_bytes.size() > cut) void'(str_bytes.pop_back());
        end else if (pick >= 70) begin
          str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end
      sent_here += str_bytes.size();
      // final flag on the last byte resyncs after damaged strings
      send_pending(pick >= 70 || pick < 8);
    end
    drain();
    sender_gap_max = 10;
    sink_gap_max = 10;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    clear_decoder();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_and_escapes();
    test_unicode();
    test_error_paths();
    test_unterminated();
    test_back_pressure();
    test_random_strings();

    // settle past the pipeline latency
    repeat (10) @(negedge clk);
    $display("tb: %0d bytes sent, %0d results checked", bytes_sent, results_seen);
    $display("tb: %0d strings closed, %0d ended in an error status",
             strings_done, strings_failed);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
